### hdl/cfq_pkg.sv
// Package for the cell fault qualifier: payload structs, register codes,
// configuration bundle and the debounce counter update function.
// No dependencies.
package cfq_pkg;

  localparam int unsigned NumCellsDef = 16;
  localparam int unsigned CellW       = 4;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned CountW      = 8;
  localparam int unsigned NumFaults   = 4;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  // Flag bit positions
  localparam int unsigned FltOver  = 0;
  localparam int unsigned FltUnder = 1;
  localparam int unsigned FltOpen  = 2;
  localparam int unsigned FltSpike = 3;

  // Register reset values
  localparam logic [SampleW-1:0] OverLimitRst  = 16'd42000;
  localparam logic [SampleW-1:0] UnderLimitRst = 16'd25000;
  localparam logic [SampleW-1:0] OpenLimitRst  = 16'd1000;
  localparam logic [SampleW-1:0] SpikeLimitRst = 16'd5000;
  localparam logic [CountW-1:0]  DebounceRst   = 8'd3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OVER_LIMIT  = 3'd0,
    REG_UNDER_LIMIT = 3'd1,
    REG_OPEN_LIMIT  = 3'd2,
    REG_SPIKE_LIMIT = 3'd3,
    REG_DEBOUNCE    = 3'd4
  } cfq_reg_e;

  typedef struct packed {
    logic [CellW-1:0]   cell_index;
    logic [SampleW-1:0] cell_sample;
  } cfq_in_t;

  typedef struct packed {
    logic [CellW-1:0] cell_index_out;
    logic             over_voltage_flag;
    logic             under_voltage_flag;
    logic             open_wire_flag;
    logic             spike_flag;
  } cfq_out_t;

  typedef struct packed {
    logic [SampleW-1:0] over_limit;
    logic [SampleW-1:0] under_limit;
    logic [SampleW-1:0] open_limit;
    logic [SampleW-1:0] spike_limit;
    logic [CountW-1:0]  debounce;
  } cfq_cfg_t;

  // Classified request moving from front end to back end
  typedef struct packed {
    logic [CellW-1:0]   cell_idx;
    logic [SampleW-1:0] sample;
    logic               in_range;
    logic               over;
    logic               under;
    logic               open;
  } cfq_cls_t;

  typedef struct packed {
    logic [CountW-1:0] cnt;
    logic              flag;
  } cfq_qual_t;

  // Saturating up/down debounce counter with hysteresis on its flag
  function automatic cfq_qual_t cfq_qualify(logic [CountW-1:0] cnt, logic cond,
                                            logic flag, logic [CountW-1:0] limit);
    cfq_qual_t r;
    r.cnt  = cnt;
    r.flag = flag;
    if (cond) begin
      if (cnt < limit) r.cnt = cnt + CountW'(1);
      if (r.cnt >= limit) r.flag = 1'b1;
    end else begin
      if (cnt != '0) r.cnt = cnt - CountW'(1);
      if (r.cnt == '0) r.flag = 1'b0;
    end
    return r;
  endfunction

endpackage

### hdl/cfq_front.sv
// Front end: accepts sample requests and classifies them against the
// voltage limits. Depends on cfq_pkg.
module cfq_front import cfq_pkg::*; #(
  parameter int unsigned NUM_CELLS = NumCellsDef
) (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cfq_in_t  in_data_i,
  input  cfq_cfg_t cfg_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cfq_cls_t q_data_o
);

  // Stall only while the queue has no room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the sample on raw counts
  always_comb begin
    q_data_o.cell_idx = in_data_i.cell_index;
    q_data_o.sample   = in_data_i.cell_sample;
    q_data_o.in_range = 32'(in_data_i.cell_index) < NUM_CELLS;
    q_data_o.over     = in_data_i.cell_sample > cfg_i.over_limit;
    q_data_o.under    = in_data_i.cell_sample < cfg_i.under_limit;
    q_data_o.open     = in_data_i.cell_sample < cfg_i.open_limit;
  end

endmodule

### hdl/cfq_queue.sv
// Two-entry queue between front and back end; push and pop may happen in the same cycle.
// Depends on cfq_pkg.
module cfq_queue import cfq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cfq_cls_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output cfq_cls_t pop_data_o
);

  cfq_cls_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign valid_o    = count_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### hdl/cfq_back.sv
// Back end: per-cell counters, previous samples and flags, spike check,
// debounce update and the output register. Depends on cfq_pkg.
module cfq_back import cfq_pkg::*; #(
  parameter int unsigned NUM_CELLS = NumCellsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfq_cfg_t cfg_i,
  input  logic     q_valid_i,
  input  cfq_cls_t q_data_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cfq_out_t out_data_o
);

  // Only cells reachable by the index field get storage
  localparam int unsigned Depth = (NUM_CELLS < (1 << CellW)) ? NUM_CELLS : (1 << CellW);
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [CountW-1:0]    cnt_q   [Depth][NumFaults];
  logic [SampleW-1:0]   prev_q  [Depth];
  logic [NumFaults-1:0] flags_q [Depth];

  logic                 out_valid_q, out_valid_d;
  cfq_out_t             out_q, out_d;

  logic [IdxW-1:0]      idx;
  logic [SampleW:0]     diff;
  logic [SampleW-1:0]   step;
  logic [NumFaults-1:0] cond;
  logic [NumFaults-1:0] flags_d;
  logic [CountW-1:0]    cnt_d [NumFaults];
  cfq_qual_t            qual  [NumFaults];

  assign idx     = q_data_i.cell_idx[IdxW-1:0];
  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  // Spike step against the previous sample of the cell
  always_comb begin
    diff = {1'b0, q_data_i.sample} - {1'b0, prev_q[idx]};
    step = diff[SampleW] ? (prev_q[idx] - q_data_i.sample) : diff[SampleW-1:0];
    cond[FltOver]  = q_data_i.over;
    cond[FltUnder] = q_data_i.under;
    cond[FltOpen]  = q_data_i.open;
    cond[FltSpike] = step > cfg_i.spike_limit;
  end

  // Update counters and flags of the addressed cell
  always_comb begin
    for (int k = 0; k < NumFaults; k++) begin
      qual[k]    = cfq_qualify(cnt_q[idx][k], cond[k], flags_q[idx][k], cfg_i.debounce);
      cnt_d[k]   = qual[k].cnt;
      flags_d[k] = qual[k].flag;
    end
  end

  // Form the result; out-of-range cells report no faults
  always_comb begin
    out_d.cell_index_out     = q_data_i.cell_idx;
    out_d.over_voltage_flag  = q_data_i.in_range && flags_d[FltOver];
    out_d.under_voltage_flag = q_data_i.in_range && flags_d[FltUnder];
    out_d.open_wire_flag     = q_data_i.in_range && flags_d[FltOpen];
    out_d.spike_flag         = q_data_i.in_range && flags_d[FltSpike];
    out_valid_d = q_pop_o || (out_valid_q && out_stall_i);
  end

  // Per-cell state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < Depth; c++) begin
        prev_q[c]  <= '0;
        flags_q[c] <= '0;
        for (int k = 0; k < NumFaults; k++) cnt_q[c][k] <= '0;
      end
    end else if (q_pop_o && q_data_i.in_range) begin
      prev_q[idx]  <= q_data_i.sample;
      flags_q[idx] <= flags_d;
      for (int k = 0; k < NumFaults; k++) cnt_q[idx][k] <= cnt_d[k];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/cell_fault_qualifier_core.sv
// Top level of the cell fault qualifier: configuration registers and the
// front end, queue and back end. Depends on cfq_pkg, cfq_front, cfq_queue, cfq_back.
//
// Each accepted sample request returns one result with that cell's four
// debounced fault flags. The block sustains one sample per clock while the
// output is not stalled; a result is presented once its request has passed
// through the two-entry queue and been registered at the back end's output.
// The back end does a read-modify-write of the addressed cell's counters,
// previous sample and flags, held in flip-flops that reset clears.
// Input stall rises only when the queue is full behind a stalled output.
// Configuration writes are always ready and are registered before they take effect.
module cell_fault_qualifier_core import cfq_pkg::*; #(
  parameter int unsigned NUM_CELLS = NumCellsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cfq_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cfq_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfq_cfg_t cfg_q, cfg_d;
  logic     q_push, q_full, q_pop, q_valid;
  cfq_cls_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  // Decode register writes; unknown indexes drop
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfq_reg_e'(cfg_index_i))
        REG_OVER_LIMIT:  cfg_d.over_limit  = cfg_data_i;
        REG_UNDER_LIMIT: cfg_d.under_limit = cfg_data_i;
        REG_OPEN_LIMIT:  cfg_d.open_limit  = cfg_data_i;
        REG_SPIKE_LIMIT: cfg_d.spike_limit = cfg_data_i;
        REG_DEBOUNCE:    cfg_d.debounce    = cfg_data_i[CountW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.over_limit  <= OverLimitRst;
      cfg_q.under_limit <= UnderLimitRst;
      cfg_q.open_limit  <= OpenLimitRst;
      cfg_q.spike_limit <= SpikeLimitRst;
      cfg_q.debounce    <= DebounceRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cfq_front #(.NUM_CELLS(NUM_CELLS)) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  cfq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  cfq_back #(.NUM_CELLS(NUM_CELLS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### hdl/cfq_checker.sv
// Port-level checks for the cell fault qualifier, bound to the top level.
// Depends on cfq_pkg and cell_fault_qualifier_core.
module cfq_checker import cfq_pkg::*; #(
  parameter int unsigned NUM_CELLS = NumCellsDef
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input cfq_out_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Input stalls only behind a pending result
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Stall releases only after the output side moved
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> $past(!out_stall_i))
    else $error("stall released without output progress");

  // Cells out of range report no faults
  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (32'(out_data_o.cell_index_out) >= NUM_CELLS) |->
      !out_data_o.over_voltage_flag && !out_data_o.under_voltage_flag &&
      !out_data_o.open_wire_flag && !out_data_o.spike_flag)
    else $error("flags set for cell out of range");

endmodule

bind cell_fault_qualifier_core cfq_checker #(.NUM_CELLS(NUM_CELLS)) u_cfq_checker (.*);

### tb/sv/cfq_tb_pkg.sv
`timescale 1ns / 1ps
// Flag tracker for the cell fault qualifier testbench: mirrors the per-cell
// debounce counters and flags, queues expected results and checks them.
// Depends on cfq_pkg.
package cfq_tb_pkg;
  import cfq_pkg::*;

  localparam int unsigned NumCells  = NumCellsDef;
  localparam int unsigned ShowLimit = 10;

  class flag_tracker;
    logic [SampleW-1:0]   over_lim;
    logic [SampleW-1:0]   under_lim;
    logic [SampleW-1:0]   open_lim;
    logic [SampleW-1:0]   spike_lim;
    logic [CountW-1:0]    debounce;
    logic [CountW-1:0]    cnt [NumFaults][NumCells];
    logic [NumFaults-1:0] flags [NumCells];
    logic [SampleW-1:0]   prev_sample [NumCells];
    cfq_out_t             expected_flags [$];
    int unsigned          mismatches;

    function new();
      over_lim   = OverLimitRst;
      under_lim  = UnderLimitRst;
      open_lim   = OpenLimitRst;
      spike_lim  = SpikeLimitRst;
      debounce   = DebounceRst;
      mismatches = 0;
      for (int c = 0; c < NumCells; c++) begin
        flags[c]       = '0;
        prev_sample[c] = '0;
        for (int f = 0; f < NumFaults; f++) cnt[f][c] = '0;
      end
    endfunction

    // Mirror a register write; indexes past the debounce register are dropped
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      unique case (idx)
        REG_OVER_LIMIT:  over_lim  = data;
        REG_UNDER_LIMIT: under_lim = data;
        REG_OPEN_LIMIT:  open_lim  = data;
        REG_SPIKE_LIMIT: spike_lim = data;
        REG_DEBOUNCE:    debounce  = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    // Advance one saturating counter and update its flag with hysteresis
    function void qualify(int unsigned pos, int unsigned cidx, bit cond);
      if (cond) begin
        if (cnt[pos][cidx] < debounce) cnt[pos][cidx] = cnt[pos][cidx] + CountW'(1);
        if (cnt[pos][cidx] >= debounce) flags[cidx][pos] = 1'b1;
      end else begin
        if (cnt[pos][cidx] != '0) cnt[pos][cidx] = cnt[pos][cidx] - CountW'(1);
        if (cnt[pos][cidx] == '0) flags[cidx][pos] = 1'b0;
      end
    endfunction

    // Work out the flags that an accepted sample request must return
    function void note_sample(cfq_in_t req);
      int unsigned        c;
      logic [SampleW-1:0] s;
      logic [SampleW-1:0] delta;
      cfq_out_t           want;
      c    = 32'(req.cell_index);
      s    = req.cell_sample;
      want = '0;
      want.cell_index_out = req.cell_index;
      if (c < NumCells) begin
        delta = (s >= prev_sample[c]) ? s - prev_sample[c] : prev_sample[c] - s;
        qualify(FltOver, c, s > over_lim);
        qualify(FltUnder, c, s < under_lim);
        qualify(FltOpen, c, s < open_lim);
        qualify(FltSpike, c, delta > spike_lim);
        prev_sample[c] = s;
        want.over_voltage_flag  = flags[c][FltOver];
        want.under_voltage_flag = flags[c][FltUnder];
        want.open_wire_flag     = flags[c][FltOpen];
        want.spike_flag         = flags[c][FltSpike];
      end
      expected_flags.push_back(want);
    endfunction

    // Compare a result with the oldest expected flags
    function void check_flags(cfq_out_t got);
      cfq_out_t want;
      if (expected_flags.size() == 0) begin
        mismatches++;
        if (mismatches <= ShowLimit)
          $display("unexpected result: cell %0d ov=%b uv=%b ow=%b sp=%b",
                   got.cell_index_out, got.over_voltage_flag, got.under_voltage_flag,
                   got.open_wire_flag, got.spike_flag);
        return;
      end
      want = expected_flags.pop_front();
      if (got.cell_index_out !== want.cell_index_out ||
          got.over_voltage_flag !== want.over_voltage_flag ||
          got.under_voltage_flag !== want.under_voltage_flag ||
          got.open_wire_flag !== want.open_wire_flag ||
          got.spike_flag !== want.spike_flag) begin
        mismatches++;
        if (mismatches <= ShowLimit)
          $display("flag mismatch: expected cell %0d flags %b%b%b%b, got cell %0d flags %b%b%b%b",
                   want.cell_index_out, want.over_voltage_flag, want.under_voltage_flag,
                   want.open_wire_flag, want.spike_flag,
                   got.cell_index_out, got.over_voltage_flag, got.under_voltage_flag,
                   got.open_wire_flag, got.spike_flag);
      end
    endfunction

    function int unsigned pending();
      return expected_flags.size();
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the cell fault qualifier testbench: clock, reset, sample and
// register drivers, output stall and result monitor. Depends on cfq_pkg,
// cfq_tb_pkg and cell_fault_qualifier_core.
module tb_top;
  import cfq_pkg::*;
  import cfq_tb_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 105;
  localparam int unsigned NumPhases  = 8;

  // Sample targets for a run of requests on one cell
  localparam int unsigned AimOver   = 0;
  localparam int unsigned AimUnder  = 1;
  localparam int unsigned AimOpen   = 2;
  localparam int unsigned AimSpike  = 3;
  localparam int unsigned AimRail   = 4;
  localparam int unsigned AimSteady = 5;
  localparam int unsigned AimAny    = 6;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  cfq_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  cfq_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycles;
  flag_tracker tracker;

  cell_fault_qualifier_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_flags(out_data_o);
  end

  // Abort a run that hangs
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Pick a sample around the chosen target, clamped to the sample range
  function automatic logic [SampleW-1:0] pick_sample(logic [CellW-1:0] cell_id,
                                                     int unsigned aim);
    int v;
    int p;
    int l;
    p = int'(tracker.prev_sample[cell_id]);
    l = int'(tracker.spike_lim);
    unique case (aim)
      AimOver:   v = int'(tracker.over_lim) + int'($urandom_range(0, 6)) - 3;
      AimUnder:  v = int'(tracker.under_lim) + int'($urandom_range(0, 6)) - 3;
      AimOpen:   v = int'(tracker.open_lim) + int'($urandom_range(0, 6)) - 3;
      AimSpike:  v = ($urandom_range(0, 1) ? p + l : p - l) + int'($urandom_range(0, 4)) - 2;
      AimRail:   v = $urandom_range(0, 1) ? 65535 : 0;
      AimSteady: v = p + int'($urandom_range(0, 8)) - 4;
      default:   v = int'($urandom_range(0, 65535));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[SampleW-1:0];
  endfunction

  // Offer one sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic [CellW-1:0] cell_id, input logic [SampleW-1:0] value);
    cfq_in_t req;
    req.cell_index  = cell_id;
    req.cell_sample = value;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_sample(req);
    @(negedge clk_i);
  endtask

  // Write one register; the caller drops valid after the last write
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Stop offering requests and wait until every result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [CellW-1:0]    cell_id;
    logic [CfgDataW-1:0] regs [5];
    int unsigned         sent;
    int unsigned         run_len;
    int unsigned         aim;

    tracker        = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_OVER_LIMIT;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Hold cell 0 over the limit until its flag sets, then drop to zero
    repeat (3) send_sample(4'd0, 16'hFFFF);
    repeat (2) send_sample(4'd0, 16'h0000);
    // First samples of fresh cells step against a zero history
    send_sample(4'd15, 16'h0000);
    send_sample(4'd1, 16'd30000);
    settle();

    // Writes past the last register must leave the settings alone
    for (int k = 1; k <= 3; k++)
      cfg_write(CfgIdxW'(int'(REG_DEBOUNCE) + k), 16'($urandom_range(0, 65535)));
    cfg_write(REG_DEBOUNCE, 16'd10);
    cfg_valid_i <= 1'b0;
    repeat (8) send_sample(4'd2, 16'd50000);
    settle();

    // Lower the debounce count below a running counter: flag sets at once
    cfg_write(REG_DEBOUNCE, 16'd2);
    cfg_valid_i <= 1'b0;
    repeat (2) send_sample(4'd2, 16'd50000);
    settle();

    // Zero debounce count, upper data bits dropped: flags follow conditions
    cfg_write(REG_DEBOUNCE, 16'hAB00);
    cfg_valid_i <= 1'b0;
    send_sample(4'd3, 16'hFFFF);
    send_sample(4'd3, 16'd20000);
    send_sample(4'd3, 16'h0000);
    send_sample(4'd3, 16'd500);
    settle();

    // Random phases, each with its settings and one of four idle and stall patterns
    for (int ph = 0; ph < NumPhases; ph++) begin
      unique case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      unique case (ph)
        0: begin
          regs[REG_OVER_LIMIT]  = OverLimitRst;
          regs[REG_UNDER_LIMIT] = UnderLimitRst;
          regs[REG_OPEN_LIMIT]  = OpenLimitRst;
          regs[REG_SPIKE_LIMIT] = SpikeLimitRst;
          regs[REG_DEBOUNCE]    = {8'h00, DebounceRst};
        end
        1: begin
          regs[REG_OVER_LIMIT]  = 16'h0000;
          regs[REG_UNDER_LIMIT] = 16'h0000;
          regs[REG_OPEN_LIMIT]  = 16'h0000;
          regs[REG_SPIKE_LIMIT] = 16'h0000;
          regs[REG_DEBOUNCE]    = 16'd1;
        end
        2: begin
          regs[REG_OVER_LIMIT]  = 16'hFFFF;
          regs[REG_UNDER_LIMIT] = 16'hFFFF;
          regs[REG_OPEN_LIMIT]  = 16'hFFFF;
          regs[REG_SPIKE_LIMIT] = 16'hFFFF;
          regs[REG_DEBOUNCE]    = 16'hFFFF;
        end
        default: begin
          regs[REG_OVER_LIMIT]  = 16'($urandom_range(30000, 65535));
          regs[REG_UNDER_LIMIT] = 16'($urandom_range(10000, 40000));
          regs[REG_OPEN_LIMIT]  = 16'($urandom_range(0, 5000));
          regs[REG_SPIKE_LIMIT] = 16'($urandom_range(0, 20000));
          regs[REG_DEBOUNCE]    = {8'($urandom_range(0, 255)), 8'($urandom_range(1, 6))};
        end
      endcase
      cfg_write(REG_OVER_LIMIT, regs[REG_OVER_LIMIT]);
      cfg_write(REG_UNDER_LIMIT, regs[REG_UNDER_LIMIT]);
      cfg_write(REG_OPEN_LIMIT, regs[REG_OPEN_LIMIT]);
      cfg_write(REG_SPIKE_LIMIT, regs[REG_SPIKE_LIMIT]);
      cfg_write(REG_DEBOUNCE, regs[REG_DEBOUNCE]);
      cfg_valid_i <= 1'b0;

      // Runs on one cell aimed at one condition, so counters climb and fall
      sent = 0;
      while (sent < PhaseItems) begin
        cell_id = ($urandom_range(0, 3) != 0) ? CellW'($urandom_range(0, 3))
                                              : CellW'($urandom_range(0, 15));
        run_len = $urandom_range(1, 8);
        aim     = $urandom_range(AimOver, AimAny);
        for (int r = 0; r < run_len && sent < PhaseItems; r++) begin
          send_sample(cell_id, pick_sample(cell_id, aim));
          sent++;
        end
      end
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
